[rtl/assert_macros.svh]
// Assertion macros used by the checker file tawl_checker.sv of this project.
// Needs a clk and an rst signal in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define AST_RUN(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed while running");

// Property checked at every rising edge, reset included.
`define AST_ALL(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed around reset");

`endif

[rtl/tawl_pkg.sv]
`timescale 1ns / 1ps
// Types and constants of the tick accounting unit.
// Used by the cell, count and top level modules; depends on nothing.
package tawl_pkg;

  typedef enum logic [1:0] {
    KIND_IDLE     = 2'd0,
    KIND_USER     = 2'd1,
    KIND_KERNEL   = 2'd2,
    KIND_DEFERRED = 2'd3
  } kind_t;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  localparam logic [1:0] REG_USEC_PER_TICK    = 2'd0;
  localparam logic [1:0] REG_CLOCK_STEP       = 2'd1;
  localparam logic [1:0] REG_QUANTUM_PER_TICK = 2'd2;

  localparam logic [19:0] USEC_PER_TICK_RST    = 20'd10000;
  localparam logic [31:0] CLOCK_STEP_RST       = 32'd11931;
  localparam logic [7:0]  QUANTUM_PER_TICK_RST = 8'd1;

  localparam logic [20:0] USEC_ROLL       = 21'd1000000;
  localparam logic [20:0] USEC_ROLL_TWICE = 21'd2000000;
  localparam logic [19:0] USEC_MAX        = 20'd999999;
  localparam logic signed [15:0] QUANTUM_MIN = 16'sh8000;

  typedef logic [6:0] count_t;

  typedef struct packed {
    logic [31:0]        tick_count;
    logic [31:0]        clock_count;
    logic [31:0]        seconds;
    logic [19:0]        microseconds;
    logic [31:0]        uptime_seconds;
    kind_t              load_kind;
    logic signed [15:0] quantum_out;
    logic               preempt;
    count_t             count_user;
    count_t             count_kernel;
    count_t             count_deferred;
    count_t             count_idle;
  } res_t;

endpackage

[rtl/tick_accounting_with_load_window_unit.sv]
`timescale 1ns / 1ps
// Tick accounting unit. A result is registered in the output register, or in the skid
// stage while that is full, so an item can enter while a result waits. Throughput: one
// item per cycle while the skid stage is empty. The load window is a chain of cells
// that shifts once per tick. Synchronous reset puts every cell to idle and the counters
// to their start values; no clearing pass. Uses tawl_pkg, tawl_cell, tawl_counts.
module tick_accounting_with_load_window_unit import tawl_pkg::*; #(
  parameter int LOAD_WINDOW = 100
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic               user_mode,
  input  logic               in_deferred,
  input  logic               idle_thread,
  input  logic signed [15:0] quantum_in,
  input  logic [31:0]        new_seconds,
  input  logic [19:0]        new_microseconds,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        tick_count,
  output logic [31:0]        clock_count,
  output logic [31:0]        seconds,
  output logic [19:0]        microseconds,
  output logic [31:0]        uptime_seconds,
  output logic [1:0]         load_kind,
  output logic signed [15:0] quantum_out,
  output logic               preempt,
  output logic [6:0]         count_user,
  output logic [6:0]         count_kernel,
  output logic [6:0]         count_deferred,
  output logic [6:0]         count_idle
);

  localparam int CW = $clog2(LOAD_WINDOW + 1);

  logic [19:0] usec_per_tick;
  logic [31:0] clock_step;
  logic [7:0]  quantum_per_tick;

  logic [31:0] tick_counter, tick_counter_next;
  logic [31:0] clock_counter, clock_counter_next;
  logic [31:0] wall_seconds, wall_seconds_next;
  logic [19:0] wall_usec, wall_usec_next;
  logic [31:0] boot_seconds, boot_seconds_next;

  logic accept, tick, clock_load, out_take;
  kind_t new_kind, old_kind;
  kind_t chain [LOAD_WINDOW+1];
  logic [3:0][CW-1:0] cnt_next;

  logic [20:0] usec_sum;
  logic [19:0] usec_load;
  logic signed [16:0] q_diff;
  logic signed [15:0] q_sat;
  res_t res_new, o_res, s_res;
  logic s_valid;

  assign in_ready   = !s_valid;
  assign accept     = in_valid && in_ready;
  assign tick       = accept && (op == OP_TICK);
  assign clock_load = accept && (op == OP_SET);
  assign out_take   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      usec_per_tick    <= USEC_PER_TICK_RST;
      clock_step       <= CLOCK_STEP_RST;
      quantum_per_tick <= QUANTUM_PER_TICK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_USEC_PER_TICK:    usec_per_tick    <= cfg_data[19:0];
        REG_CLOCK_STEP:       clock_step       <= cfg_data;
        REG_QUANTUM_PER_TICK: quantum_per_tick <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_deferred) begin
      new_kind = KIND_DEFERRED;
    end else if (user_mode) begin
      new_kind = KIND_USER;
    end else if (idle_thread) begin
      new_kind = KIND_IDLE;
    end else begin
      new_kind = KIND_KERNEL;
    end
  end

  // A step above 1000000 can carry up to two seconds in one tick.
  assign usec_sum  = {1'b0, wall_usec} + {1'b0, usec_per_tick};
  assign usec_load = (new_microseconds > USEC_MAX) ? USEC_MAX : new_microseconds;

  always_comb begin
    tick_counter_next  = tick_counter;
    clock_counter_next = clock_counter;
    wall_seconds_next  = wall_seconds;
    wall_usec_next     = wall_usec;
    boot_seconds_next  = boot_seconds;
    if (tick) begin
      tick_counter_next  = tick_counter + 32'd1;
      clock_counter_next = clock_counter + clock_step;
      if (usec_sum >= USEC_ROLL_TWICE) begin
        wall_seconds_next = wall_seconds + 32'd2;
        wall_usec_next    = 20'(usec_sum - USEC_ROLL_TWICE);
      end else if (usec_sum >= USEC_ROLL) begin
        wall_seconds_next = wall_seconds + 32'd1;
        wall_usec_next    = 20'(usec_sum - USEC_ROLL);
      end else begin
        wall_usec_next    = usec_sum[19:0];
      end
    end else if (clock_load) begin
      // Boot time moves with the clock so that uptime is kept.
      boot_seconds_next = boot_seconds + (new_seconds - wall_seconds);
      wall_seconds_next = new_seconds;
      wall_usec_next    = usec_load;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter  <= '0;
      clock_counter <= '0;
      wall_seconds  <= '0;
      wall_usec     <= '0;
      boot_seconds  <= '0;
    end else begin
      tick_counter  <= tick_counter_next;
      clock_counter <= clock_counter_next;
      wall_seconds  <= wall_seconds_next;
      wall_usec     <= wall_usec_next;
      boot_seconds  <= boot_seconds_next;
    end
  end

  // The oldest kind falls out of the far end of the chain on every tick.
  assign chain[0] = new_kind;
  for (genvar i = 0; i < LOAD_WINDOW; i++) begin : g_cell
    tawl_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (tick),
      .d     (chain[i]),
      .q     (chain[i+1])
    );
  end
  assign old_kind = chain[LOAD_WINDOW];

  tawl_counts #(.LOAD_WINDOW(LOAD_WINDOW)) u_counts (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick),
    .old_kind (old_kind),
    .new_kind (new_kind),
    .cnt_next (cnt_next)
  );

  // A difference below the 16-bit range shows as sign set with bit 15 clear.
  assign q_diff = {quantum_in[15], quantum_in} - $signed({9'd0, quantum_per_tick});
  assign q_sat  = (q_diff[16] && !q_diff[15]) ? QUANTUM_MIN : q_diff[15:0];

  always_comb begin
    res_new.tick_count     = tick_counter_next;
    res_new.clock_count    = clock_counter_next;
    res_new.seconds        = wall_seconds_next;
    res_new.microseconds   = wall_usec_next;
    res_new.uptime_seconds = wall_seconds_next - boot_seconds_next;
    res_new.load_kind      = KIND_IDLE;
    res_new.quantum_out    = '0;
    res_new.preempt        = 1'b0;
    if (op == OP_TICK) begin
      res_new.load_kind   = new_kind;
      res_new.quantum_out = q_sat;
      res_new.preempt     = q_sat[15] || (q_sat == '0);
    end
    res_new.count_user     = count_t'(cnt_next[KIND_USER]);
    res_new.count_kernel   = count_t'(cnt_next[KIND_KERNEL]);
    res_new.count_deferred = count_t'(cnt_next[KIND_DEFERRED]);
    res_new.count_idle     = count_t'(cnt_next[KIND_IDLE]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      s_valid   <= 1'b0;
    end else if (s_valid) begin
      if (out_take) begin
        o_res   <= s_res;
        s_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || out_take) begin
        o_res     <= res_new;
        out_valid <= 1'b1;
      end else begin
        s_res   <= res_new;
        s_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  assign tick_count     = o_res.tick_count;
  assign clock_count    = o_res.clock_count;
  assign seconds        = o_res.seconds;
  assign microseconds   = o_res.microseconds;
  assign uptime_seconds = o_res.uptime_seconds;
  assign load_kind      = o_res.load_kind;
  assign quantum_out    = o_res.quantum_out;
  assign preempt        = o_res.preempt;
  assign count_user     = o_res.count_user;
  assign count_kernel   = o_res.count_kernel;
  assign count_deferred = o_res.count_deferred;
  assign count_idle     = o_res.count_idle;

endmodule

[rtl/tawl_cell.sv]
`timescale 1ns / 1ps
// One slot of the load window: holds the kind of one past tick.
// Depends on tawl_pkg.
module tawl_cell import tawl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  kind_t d,
  output kind_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= KIND_IDLE;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

[rtl/tawl_counts.sv]
`timescale 1ns / 1ps
// Running per-kind tick counts over the load window.
// Depends on tawl_pkg.
module tawl_counts import tawl_pkg::*; #(
  parameter int LOAD_WINDOW = 100,
  localparam int CW = $clog2(LOAD_WINDOW + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick,
  input  kind_t              old_kind,
  input  kind_t              new_kind,
  output logic [3:0][CW-1:0] cnt_next
);

  logic [3:0][CW-1:0] cnt;

  // The kind leaving the window loses one, the kind entering gains one.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cnt_next[k] = cnt[k];
      if (tick) begin
        if (old_kind == kind_t'(2'(k)) && cnt[k] != '0) begin
          cnt_next[k] = cnt_next[k] - CW'(1);
        end
        if (new_kind == kind_t'(2'(k))) begin
          cnt_next[k] = cnt_next[k] + CW'(1);
        end
      end
    end
  end

  // The idle count sits in the lowest slot and starts at the full window.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= {{(3*CW){1'b0}}, CW'(LOAD_WINDOW)};
    end else begin
      cnt <= cnt_next;
    end
  end

endmodule

[rtl/tawl_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the tick accounting unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tawl_checker #(
  parameter int LOAD_WINDOW = 100
) (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [31:0]        tick_count,
  input logic [19:0]        microseconds,
  input logic signed [15:0] quantum_out,
  input logic               preempt,
  input logic [6:0]         count_user,
  input logic [6:0]         count_kernel,
  input logic [6:0]         count_deferred,
  input logic [6:0]         count_idle
);

  logic [6:0] count_sum;
  assign count_sum = count_user + count_kernel + count_deferred + count_idle;

  `AST_ALL(a_reset_empty, rst |=> !out_valid)
  `AST_RUN(a_hold, out_valid && !out_ready |=> out_valid && $stable(tick_count))
  `AST_RUN(a_window_sum, out_valid |-> count_sum == 7'(LOAD_WINDOW))
  `AST_RUN(a_usec_range, out_valid |-> microseconds <= 20'd999999)
  `AST_RUN(a_preempt, out_valid && preempt |-> quantum_out[15] || quantum_out == 16'sd0)

endmodule

bind tick_accounting_with_load_window_unit tawl_checker #(
  .LOAD_WINDOW(LOAD_WINDOW)
) u_tawl_checker (.*);

[test/tick_accounting_checker.sv]
`timescale 1ns / 1ps
// Checker for the tick accounting unit: watches the register port and both item
// channels, predicts every result and compares it field by field. Uses tawl_pkg.
module tick_accounting_checker import tawl_pkg::*; #(
  parameter int LOAD_WINDOW = 100
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               op,
  input  logic               user_mode,
  input  logic               in_deferred,
  input  logic               idle_thread,
  input  logic signed [15:0] quantum_in,
  input  logic [31:0]        new_seconds,
  input  logic [19:0]        new_microseconds,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [31:0]        tick_count,
  input  logic [31:0]        clock_count,
  input  logic [31:0]        seconds,
  input  logic [19:0]        microseconds,
  input  logic [31:0]        uptime_seconds,
  input  logic [1:0]         load_kind,
  input  logic signed [15:0] quantum_out,
  input  logic               preempt,
  input  logic [6:0]         count_user,
  input  logic [6:0]         count_kernel,
  input  logic [6:0]         count_deferred,
  input  logic [6:0]         count_idle,
  output int                 failures,
  output int                 outstanding
);

  logic [19:0] usec_step;
  logic [31:0] clock_step;
  logic [7:0]  quantum_step;

  logic [31:0] ticks_seen;
  logic [31:0] clocks_seen;
  logic [31:0] wall_sec;
  logic [31:0] wall_usec;
  logic [31:0] boot_sec;
  kind_t       window [LOAD_WINDOW];
  int          slot;
  count_t      kind_tally [0:3];

  res_t        due_reports [$];
  int          mismatches = 0;
  int          reported = 0;

  task automatic clear_model();
    usec_step = USEC_PER_TICK_RST;
    clock_step = CLOCK_STEP_RST;
    quantum_step = QUANTUM_PER_TICK_RST;
    ticks_seen = '0;
    clocks_seen = '0;
    wall_sec = '0;
    wall_usec = '0;
    boot_sec = '0;
    for (int i = 0; i < LOAD_WINDOW; i++) window[i] = KIND_IDLE;
    slot = 0;
    kind_tally[KIND_IDLE] = count_t'(LOAD_WINDOW);
    kind_tally[KIND_USER] = '0;
    kind_tally[KIND_KERNEL] = '0;
    kind_tally[KIND_DEFERRED] = '0;
  endtask

  // Applies one accepted item to the model and queues the result it must produce.
  task automatic account_item();
    res_t  r;
    kind_t k;
    kind_t old;
    int    q;
    r = '0;
    if (op == OP_TICK) begin
      ticks_seen = ticks_seen + 1;
      clocks_seen = clocks_seen + clock_step;
      wall_usec = wall_usec + usec_step;
      // A step of more than a full second can need two rollovers.
      while (wall_usec >= USEC_ROLL) begin
        wall_sec = wall_sec + 1;
        wall_usec = wall_usec - USEC_ROLL;
      end
      if (in_deferred) k = KIND_DEFERRED;
      else if (user_mode) k = KIND_USER;
      else if (idle_thread) k = KIND_IDLE;
      else k = KIND_KERNEL;
      old = window[slot];
      if (kind_tally[old] > 0) kind_tally[old] = kind_tally[old] - 7'd1;
      kind_tally[k] = kind_tally[k] + 7'd1;
      window[slot] = k;
      slot = (slot == LOAD_WINDOW - 1) ? 0 : slot + 1;
      q = int'(quantum_in) - int'(quantum_step);
      if (q < int'(QUANTUM_MIN)) q = int'(QUANTUM_MIN);
      r.load_kind = k;
      r.quantum_out = q[15:0];
      r.preempt = (q <= 0);
    end else begin
      // Boot time moves with the clock so that uptime is kept.
      boot_sec = boot_sec + (new_seconds - wall_sec);
      wall_sec = new_seconds;
      wall_usec = (new_microseconds > USEC_MAX) ? 32'(USEC_MAX) : 32'(new_microseconds);
      r.load_kind = KIND_IDLE;
    end
    r.tick_count = ticks_seen;
    r.clock_count = clocks_seen;
    r.seconds = wall_sec;
    r.microseconds = wall_usec[19:0];
    r.uptime_seconds = wall_sec - boot_sec;
    r.count_user = kind_tally[KIND_USER];
    r.count_kernel = kind_tally[KIND_KERNEL];
    r.count_deferred = kind_tally[KIND_DEFERRED];
    r.count_idle = kind_tally[KIND_IDLE];
    due_reports.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %0h, got %0h", reported, name, want, got);
    end
  endtask

  task automatic match_report();
    res_t want;
    if (due_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d arrived with no item waiting for it", reported);
    end else begin
      want = due_reports.pop_front();
      check_field("tick_count", want.tick_count, tick_count);
      check_field("clock_count", want.clock_count, clock_count);
      check_field("seconds", want.seconds, seconds);
      check_field("microseconds", want.microseconds, microseconds);
      check_field("uptime_seconds", want.uptime_seconds, uptime_seconds);
      check_field("load_kind", want.load_kind, load_kind);
      check_field("quantum_out", want.quantum_out, quantum_out);
      check_field("preempt", want.preempt, preempt);
      check_field("count_user", want.count_user, count_user);
      check_field("count_kernel", want.count_kernel, count_kernel);
      check_field("count_deferred", want.count_deferred, count_deferred);
      check_field("count_idle", want.count_idle, count_idle);
    end
    reported++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_model();
      due_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_USEC_PER_TICK:    usec_step = cfg_data[19:0];
          REG_CLOCK_STEP:       clock_step = cfg_data;
          REG_QUANTUM_PER_TICK: quantum_step = cfg_data[7:0];
          default: ;
        endcase
      end
      // The result leaving at this edge belongs to an earlier item.
      if (out_valid && out_ready) match_report();
      if (in_valid && in_ready) account_item();
    end
    failures <= mismatches;
    outstanding <= due_reports.size();
  end

endmodule

[test/tb_tick_accounting_with_load_window_unit.sv]
`timescale 1ns / 1ps
// Top of the tick accounting testbench: clock, reset, stimulus and verdict.
// Depends on tawl_pkg, the unit under test and tick_accounting_checker.
module tb_tick_accounting_with_load_window_unit;
  import tawl_pkg::*;

  localparam int LOAD_WINDOW = 100;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               op;
  logic               user_mode;
  logic               in_deferred;
  logic               idle_thread;
  logic signed [15:0] quantum_in;
  logic [31:0]        new_seconds;
  logic [19:0]        new_microseconds;
  logic               out_valid;
  logic               out_ready;
  logic [31:0]        tick_count;
  logic [31:0]        clock_count;
  logic [31:0]        seconds;
  logic [19:0]        microseconds;
  logic [31:0]        uptime_seconds;
  logic [1:0]         load_kind;
  logic signed [15:0] quantum_out;
  logic               preempt;
  logic [6:0]         count_user;
  logic [6:0]         count_kernel;
  logic [6:0]         count_deferred;
  logic [6:0]         count_idle;

  int   failures;
  int   outstanding;
  int   cycle_count = 0;
  logic idling = 1'b1;

  always #5 clk = ~clk;

  tick_accounting_with_load_window_unit #(.LOAD_WINDOW(LOAD_WINDOW)) dut (.*);

  tick_accounting_checker #(.LOAD_WINDOW(LOAD_WINDOW)) checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The result side stalls at random except during the stretch without idling.
  always @(negedge clk) begin
    if (!rst) out_ready = !idling || ($urandom_range(99) >= 23);
  end

  // Each cycle before the item the sender may sit idle, so about a quarter
  // of its cycles go unused while idling is on.
  task automatic send_item(input logic o, input logic u, input logic d, input logic i,
                           input logic [15:0] q, input logic [31:0] s,
                           input logic [19:0] us);
    @(negedge clk);
    while (idling && $urandom_range(99) < 23) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    op = o;
    user_mode = u;
    in_deferred = d;
    idle_thread = i;
    quantum_in = q;
    new_seconds = s;
    new_microseconds = us;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic random_item();
    logic        o;
    logic [15:0] q;
    logic [31:0] s;
    logic [19:0] us;
    int          pick;
    o = ($urandom_range(99) < 12) ? OP_SET : OP_TICK;
    pick = $urandom_range(9);
    if (pick < 4) q = 16'($urandom);
    else if (pick < 7) q = 16'(int'($urandom_range(0, 520)) - 260);
    else if (pick < 9) q = 16'h8000 + 16'($urandom_range(0, 300));
    else q = 16'h7FFF - 16'($urandom_range(0, 3));
    s = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3) : $urandom;
    us = ($urandom_range(9) == 0) ? 20'($urandom_range(1000000, 20'hFFFFF))
                                  : 20'($urandom_range(0, 999999));
    send_item(o, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
              q, s, us);
  endtask

  // Holds the sender until every result has been taken.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input int ph);
    logic [19:0] u;
    logic [31:0] c;
    logic [7:0]  qn;
    logic [31:0] junk;
    case (ph)
      1: begin
        u = 20'd1; c = 32'd0; qn = 8'd0;
      end
      2: begin
        u = 20'd1000000; c = 32'hFFFF_FFFF; qn = 8'd255;
      end
      3: begin
        u = 20'hFFFFF; c = $urandom; qn = 8'd1;
      end
      4: begin
        u = 20'd999999; c = 32'd1; qn = 8'd128;
      end
      default: begin
        u = 20'($urandom_range(1, 1000000)); c = $urandom; qn = 8'($urandom_range(0, 255));
      end
    endcase
    // Later phases put noise in the bits above each register's width.
    junk = (ph >= 5) ? $urandom : 32'd0;
    write_reg(REG_USEC_PER_TICK, {junk[11:0], u});
    write_reg(REG_CLOCK_STEP, c);
    write_reg(REG_QUANTUM_PER_TICK, {junk[23:0], qn});
    if (ph == 3) write_reg(REG_UNUSED, $urandom);
  endtask

  initial begin
    int ph;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    op = OP_TICK;
    user_mode = 1'b0;
    in_deferred = 1'b0;
    idle_thread = 1'b0;
    quantum_in = '0;
    new_seconds = '0;
    new_microseconds = '0;
    out_ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed items under the reset register values.
    send_item(OP_TICK, 0, 0, 0, 16'h7FFF, 32'd0, 20'd0);
    send_item(OP_TICK, 1, 0, 0, 16'h0000, 32'd0, 20'd0);
    send_item(OP_TICK, 1, 1, 1, 16'h0001, 32'd0, 20'd0);
    send_item(OP_TICK, 0, 0, 1, 16'h0002, 32'd0, 20'd0);
    send_item(OP_TICK, 1, 0, 1, 16'h8000, 32'd0, 20'd0);
    send_item(OP_TICK, 0, 1, 1, 16'h8001, 32'd0, 20'd0);
    send_item(OP_TICK, 1, 1, 0, 16'hFFFF, 32'd0, 20'd0);
    send_item(OP_SET, 0, 0, 0, 16'h0000, 32'hFFFF_FFFF, 20'd999999);
    // This tick rolls the microseconds over and wraps the seconds to zero.
    send_item(OP_TICK, 0, 0, 0, 16'h0005, 32'd0, 20'd0);
    send_item(OP_SET, 0, 0, 0, 16'h0000, 32'd0, 20'hFFFFF);
    send_item(OP_SET, 0, 0, 0, 16'h0000, 32'd12345, 20'd1000000);
    send_item(OP_SET, 1, 1, 1, 16'hFFFF, 32'hAAAA_AAAA, 20'd555555);
    send_item(OP_TICK, 0, 0, 0, 16'h5555, 32'h5555_5555, 20'hAAAAA);
    send_item(OP_TICK, 0, 0, 1, 16'hAAAA, 32'd0, 20'd0);

    for (ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        drain();
        configure(ph);
      end
      idling = (ph != 4);
      repeat (235) random_item();
    end

    drain();
    if (failures == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/tawl_pkg.sv
rtl/tawl_cell.sv
rtl/tawl_counts.sv
rtl/tick_accounting_with_load_window_unit.sv
rtl/tawl_checker.sv
test/tick_accounting_checker.sv
test/tb_tick_accounting_with_load_window_unit.sv
